### rtl/assert_macros.svh
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on the rising clock edge
`define BOL_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// next-cycle implication, sampled on the rising clock edge
`define BOL_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

### rtl/bol_pkg.sv
package bol_pkg;

   // storage geometry
   localparam int CAPACITY    = 16;
   localparam int VALUE_WIDTH = 32;
   localparam int CNT_W       = $clog2(CAPACITY + 1);
   localparam int IDX_W       = $clog2(CAPACITY);

   // port field widths
   localparam int ITEM_W      = 32;
   localparam int FIELD_CNT_W = 5;
   localparam int RSP_DATA_W  = 16;

   typedef logic [VALUE_WIDTH-1:0] value_type;
   typedef logic [CNT_W-1:0]       count_type;
   typedef logic [IDX_W-1:0]       index_type;

   // request codes
   typedef enum logic [2:0] {
      OP_PUSH_FRONT   = 3'd0,
      OP_PUSH_BACK    = 3'd1,
      OP_POP_FRONT    = 3'd2,
      OP_POP_BACK     = 3'd3,
      OP_DELETE_FIRST = 3'd4,
      OP_DELETE_ALL   = 3'd5,
      OP_SEARCH       = 3'd6,
      OP_NONE         = 3'd7
   } op_type;

   // result status codes
   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_FULL      = 2'd1,
      STATUS_EMPTY     = 2'd2,
      STATUS_NOT_FOUND = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DONE
   } state_type;

   // control broadcast to every cell of the chain
   typedef struct packed {
      logic      shift_left;
      logic      shift_right;
      logic      wr_en;
      index_type wr_idx;
      value_type wr_data;
   } cell_ctl_type;

   typedef struct packed {
      status_type status;
      logic       found;
      count_type  removed;
      count_type  entries;
   } result_type;

endpackage

### rtl/bol_cell.sv
module bol_cell
   import bol_pkg::*;
(
   input  logic         clock,
   input  cell_ctl_type ctl,
   input  index_type    cell_idx,
   input  value_type    prev_value,
   input  value_type    next_value,
   output value_type    value
);

   value_type value_ff;
   value_type value_in;

   // direct write wins over a shift of the chain
   always_comb begin
      value_in = value_ff;
      if (ctl.wr_en && (ctl.wr_idx == cell_idx)) begin
         value_in = ctl.wr_data;
      end else if (ctl.shift_left) begin
         value_in = next_value;
      end else if (ctl.shift_right) begin
         value_in = prev_value;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;

endmodule

### rtl/bol_ctrl.sv
module bol_ctrl
   import bol_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  op_type       req_op,
   input  value_type    req_key,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output result_type   rsp_result,
   input  value_type    head_value,
   output cell_ctl_type cell_ctl
);

   state_type  state_ff,   state_in;
   count_type  count_ff,   count_in;
   count_type  left_ff,    left_in;
   count_type  removed_ff, removed_in;
   logic       hit_ff,     hit_in;
   value_type  key_ff,     key_in;
   op_type     op_ff,      op_in;
   result_type pend_ff,    pend_in;
   result_type out_ff,     out_in;
   logic       out_valid_ff, out_valid_in;

   logic       out_free;
   logic       finish;
   result_type fin_res;
   count_type  count_dec;
   logic       match;
   logic       keep;

   assign out_free  = !out_valid_ff || rsp_ready;
   assign count_dec = count_ff - CNT_W'(1);
   assign match     = (head_value == key_ff);

   // next state, cell control and result
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      left_in      = left_ff;
      removed_in   = removed_ff;
      hit_in       = hit_ff;
      key_in       = key_ff;
      op_in        = op_ff;
      pend_in      = pend_ff;
      out_in       = out_ff;
      out_valid_in = out_valid_ff && !rsp_ready;
      cell_ctl     = '0;
      cell_ctl.wr_data = req_key;
      finish       = 1'b0;
      fin_res      = '0;
      req_ready    = 1'b0;
      keep         = 1'b1;

      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               fin_res.status = STATUS_OK;
               unique case (req_op) inside
                  OP_PUSH_FRONT: begin
                     finish = 1'b1;
                     if (count_ff == CNT_W'(CAPACITY)) begin
                        fin_res.status = STATUS_FULL;
                     end else begin
                        cell_ctl.shift_right = 1'b1;
                        cell_ctl.wr_en       = 1'b1;
                        cell_ctl.wr_idx      = '0;
                        count_in             = count_ff + CNT_W'(1);
                     end
                  end
                  OP_PUSH_BACK: begin
                     finish = 1'b1;
                     if (count_ff == CNT_W'(CAPACITY)) begin
                        fin_res.status = STATUS_FULL;
                     end else begin
                        cell_ctl.wr_en  = 1'b1;
                        cell_ctl.wr_idx = count_ff[IDX_W-1:0];
                        count_in        = count_ff + CNT_W'(1);
                     end
                  end
                  OP_POP_FRONT: begin
                     finish = 1'b1;
                     if (count_ff == '0) begin
                        fin_res.status = STATUS_EMPTY;
                     end else begin
                        cell_ctl.shift_left = 1'b1;
                        count_in            = count_dec;
                        fin_res.removed     = CNT_W'(1);
                     end
                  end
                  OP_POP_BACK: begin
                     finish = 1'b1;
                     if (count_ff == '0) begin
                        fin_res.status = STATUS_EMPTY;
                     end else begin
                        count_in        = count_dec;
                        fin_res.removed = CNT_W'(1);
                     end
                  end
                  OP_DELETE_FIRST, OP_DELETE_ALL, OP_SEARCH: begin
                     key_in     = req_key;
                     op_in      = req_op;
                     left_in    = count_ff;
                     removed_in = '0;
                     hit_in     = 1'b0;
                     state_in   = ST_SCAN;
                  end
                  OP_NONE: begin
                     finish = 1'b1;
                  end
               endcase
               fin_res.entries = count_in;
            end
         end
         ST_SCAN: begin
            if (left_ff != '0) begin
               // head leaves the chain and comes back in at the tail if kept
               case (op_ff)
                  OP_DELETE_ALL:   keep = !match;
                  OP_DELETE_FIRST: keep = !(match && !hit_ff);
                  default:         keep = 1'b1;
               endcase
               cell_ctl.shift_left = 1'b1;
               cell_ctl.wr_en      = keep;
               cell_ctl.wr_idx     = count_dec[IDX_W-1:0];
               cell_ctl.wr_data    = head_value;
               if (!keep) begin
                  count_in   = count_dec;
                  removed_in = removed_ff + CNT_W'(1);
               end
               hit_in  = hit_ff | match;
               left_in = left_ff - CNT_W'(1);
            end else begin
               finish          = 1'b1;
               fin_res.status  = hit_ff ? STATUS_OK : STATUS_NOT_FOUND;
               fin_res.found   = hit_ff;
               fin_res.removed = removed_ff;
               fin_res.entries = count_ff;
               state_in        = ST_IDLE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               out_in       = pend_ff;
               out_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // hand the result to the output register or park it
      if (finish) begin
         if (out_free) begin
            out_in       = fin_res;
            out_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end else begin
            pend_in  = fin_res;
            state_in = ST_DONE;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // scan and result payload
   always_ff @(posedge clock) begin
      left_ff    <= left_in;
      removed_ff <= removed_in;
      hit_ff     <= hit_in;
      key_ff     <= key_in;
      op_ff      <= op_in;
      pend_ff    <= pend_in;
      out_ff     <= out_in;
   end

   assign rsp_valid  = out_valid_ff;
   assign rsp_result = out_ff;

endmodule

### rtl/bounded_ordered_list_engine_unit.sv
// Bounded ordered list engine: a deque of up to CAPACITY signed values kept in
// a chain of cells, front in cell 0.
// Request channel (req_): tuser carries the request code, tdata the value.
// Result channel (rsp_): one transfer per request with status, found flag,
// removed count, entry count and empty flag.
// Push, pop and the unused code finish at once: with the output register free,
// the result is valid the cycle after the transfer and a new request can follow.
// Delete first, delete all and search walk the chain once, one entry per
// cycle; the next request is taken when the walk has ended. The walk length
// is set by the stored entry count; the one compare sits at the head cell.
// The result sits in an output register; a finished result waiting there does
// not block the next request. If the receiver stalls with a second result
// ready, that result is parked and request intake pauses until it moves.
// Reset (synchronous) empties the store and drops any pending result; cell
// contents are not cleared and are never read before they are written.
module bounded_ordered_list_engine_unit
   import bol_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [ITEM_W-1:0]     req_tdata,   // [31:0] item_value
   input  logic [2:0]            req_tuser,   // [2:0] req_type
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata    // [1:0] status, [2] found,
                                              // [7:3] removed_count,
                                              // [12:8] entry_count,
                                              // [13] is_empty, [15:14] zero
);

   cell_ctl_type cell_ctl;
   result_type   rsp_result;
   value_type    req_key;
   value_type    cell_value [CAPACITY];

   // stored on VALUE_WIDTH bits of the sign-extended item
   assign req_key = VALUE_WIDTH'(signed'(req_tdata));

   bol_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_tvalid),
      .req_ready  (req_tready),
      .req_op     (op_type'(req_tuser)),
      .req_key    (req_key),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_result (rsp_result),
      .head_value (cell_value[0]),
      .cell_ctl   (cell_ctl)
   );

   // chain of cells, each linked to its neighbors; the end cells see zero past the chain
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      value_type prev_value;
      value_type next_value;
      if (i == 0) begin : g_first
         assign prev_value = '0;
      end else begin : g_inner_prev
         assign prev_value = cell_value[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
         assign next_value = '0;
      end else begin : g_inner_next
         assign next_value = cell_value[i+1];
      end
      bol_cell u_cell (
         .clock      (clock),
         .ctl        (cell_ctl),
         .cell_idx   (IDX_W'(i)),
         .prev_value (prev_value),
         .next_value (next_value),
         .value      (cell_value[i])
      );
   end

   // result packing
   assign rsp_tdata = {2'b00,
                       (rsp_result.entries == '0),
                       FIELD_CNT_W'(rsp_result.entries),
                       FIELD_CNT_W'(rsp_result.removed),
                       rsp_result.found,
                       rsp_result.status};

endmodule

### rtl/bol_checker.sv
`include "assert_macros.svh"

module bol_checker
   import bol_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata
);

   // a stalled result holds
   `BOL_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))

   // entry count never passes the capacity
   `BOL_ASSERT_IMP(a_count_range, clock, reset, rsp_tvalid, rsp_tdata[12:8] <= FIELD_CNT_W'(CAPACITY))

   // empty flag agrees with the entry count
   `BOL_ASSERT_IMP(a_empty_flag, clock, reset, rsp_tvalid, rsp_tdata[13] == (rsp_tdata[12:8] == 5'd0))

   // a dropped push leaves a full store and removes nothing
   `BOL_ASSERT_IMP(a_full_push, clock, reset, rsp_tvalid && (rsp_tdata[1:0] == STATUS_FULL), (rsp_tdata[12:8] == FIELD_CNT_W'(CAPACITY)) && (rsp_tdata[7:2] == 6'd0))

   // a miss reports no hit and no removal
   `BOL_ASSERT_IMP(a_miss, clock, reset, rsp_tvalid && (rsp_tdata[1:0] == STATUS_NOT_FOUND), rsp_tdata[7:2] == 6'd0)

endmodule

bind bounded_ordered_list_engine_unit bol_checker u_bol_checker (.*);
